>>> hw/rtl/elt_pkg.sv
// Shared types, code constants and character tables for the expression language tokenizer.
// Used by elt_scan, elt_out_fifo and expression_language_tokenizer; depends on nothing.
`timescale 1ns / 1ps

package elt_pkg;

    // One emitted token as it travels through the result queue.
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_t;

    // Everything one consumed byte produces: zero, one or two tokens.
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } scan_out_t;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_IDENT  = 5'b00010,
        MODE_INT    = 5'b00100,
        MODE_ASSIGN = 5'b01000,
        MODE_BANG   = 5'b10000
    } scan_mode_t;

    localparam logic [4:0] KIND_ILLEGAL  = 5'd0;
    localparam logic [4:0] KIND_EOF      = 5'd1;
    localparam logic [4:0] KIND_IDENT    = 5'd2;
    localparam logic [4:0] KIND_INT      = 5'd3;
    localparam logic [4:0] KIND_ASSIGN   = 5'd4;
    localparam logic [4:0] KIND_PLUS     = 5'd5;
    localparam logic [4:0] KIND_MINUS    = 5'd6;
    localparam logic [4:0] KIND_BANG     = 5'd7;
    localparam logic [4:0] KIND_STAR     = 5'd8;
    localparam logic [4:0] KIND_SLASH    = 5'd9;
    localparam logic [4:0] KIND_LT       = 5'd10;
    localparam logic [4:0] KIND_GT       = 5'd11;
    localparam logic [4:0] KIND_EQ       = 5'd12;
    localparam logic [4:0] KIND_NOT_EQ   = 5'd13;
    localparam logic [4:0] KIND_COMMA    = 5'd14;
    localparam logic [4:0] KIND_SEMI     = 5'd15;
    localparam logic [4:0] KIND_LPAREN   = 5'd16;
    localparam logic [4:0] KIND_RPAREN   = 5'd17;
    localparam logic [4:0] KIND_LBRACE   = 5'd18;
    localparam logic [4:0] KIND_RBRACE   = 5'd19;
    localparam logic [4:0] KIND_KW_FIRST = 5'd20;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Keyword table: text left aligned, first character in the top byte.
    localparam int KW_COUNT = 7;
    localparam int KW_SPAN  = 6;
    localparam logic [KW_SPAN*8-1:0] KW_TEXT [KW_COUNT] = '{
        {"fn",     32'h0},
        {"let",    24'h0},
        {"true",   16'h0},
        {"false",   8'h0},
        {"if",     32'h0},
        {"else",   16'h0},
        "return"
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd4, 3'd6
    };

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    // Operators and delimiters that stand alone; anything else is illegal.
    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "<":     k = KIND_LT;
            ">":     k = KIND_GT;
            ",":     k = KIND_COMMA;
            ";":     k = KIND_SEMI;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            default: k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage

>>> hw/rtl/expression_language_tokenizer.sv
// Top level of the expression language tokenizer: input register, scanner, result queue.
// Depends on elt_pkg, elt_scan and elt_out_fifo.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata[7:0] char_code
// m_        out        m_tvalid/m_tready  m_tuser kind, m_tdata start/length, m_tlast last_of_run
//
// Each source byte is captured in an input register, decided by the scanner once the
// four-entry result queue has room for two tokens, and its tokens written into it.
// One byte is taken every cycle while the queue has room for two tokens; a byte
// that yields two tokens leaves as two transfers, so the output port sets the pace.
// Reset (aresetn low at a clock edge) empties the queue and returns the scanner to
// idle with offset zero; no clearing pass is needed.
// A stalled m_tready fills the queue and then holds s_tready low without losing data.

module expression_language_tokenizer
    import elt_pkg::*;
#(
    parameter int OFFSET_WIDTH    = 16,
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] token_start, [31:16] token_length
    output logic [4:0]  m_tuser,   // [4:0] token_kind
    output logic        m_tlast    // last_of_run
);

    logic [7:0] byte_reg;
    logic       in_valid_reg;
    logic       consume;
    logic [2:0] level;
    scan_out_t  scan_out;
    token_t     out_tok;

    // A held byte is decided once the queue can take both of its possible tokens.
    assign consume  = in_valid_reg && (level <= 3'd2);
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    elt_scan #(
        .OFFSET_WIDTH   (OFFSET_WIDTH),
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (consume),
        .in_byte (byte_reg),
        .scan_out(scan_out)
    );

    elt_out_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_en  (consume),
        .push_data(scan_out),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_tok  (out_tok),
        .level    (level)
    );

    assign m_tdata = {out_tok.length, out_tok.start};
    assign m_tuser = out_tok.kind;
    assign m_tlast = out_tok.last;

    // An end-of-text token is always the last request caused by its byte.
    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_EOF) |-> m_tlast)
        else $error("EOF token without tlast");

    // An end-of-text token carries no length.
    a_eof_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_EOF) |-> (m_tdata[31:16] == 16'd0))
        else $error("EOF token with nonzero length");

    // A zero byte always produces a final EOF token.
    a_nul_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && byte_reg == CH_NUL) |->
            ((scan_out.count == 2'd1 && scan_out.tok0.kind == KIND_EOF)
             || (scan_out.count == 2'd2 && scan_out.tok1.kind == KIND_EOF)))
        else $error("zero byte did not produce EOF");

    // The queue never holds more than its four entries.
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= 3'd4)
        else $error("result queue overflow");

endmodule

>>> hw/rtl/elt_scan.sv
// Scanner state and per-byte token decision for the expression language tokenizer.
// Depends on elt_pkg.
`timescale 1ns / 1ps

module elt_scan
    import elt_pkg::*;
#(
    parameter int OFFSET_WIDTH    = 16,
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  logic [7:0] in_byte,
    output scan_out_t scan_out
);

    scan_mode_t              mode_reg, mode_next;
    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic [15:0]             open_start_reg, open_start_next;
    logic [15:0]             open_length_reg, open_length_next;
    logic [7:0]              kw_buf_reg [KEYWORD_MAX_LEN];
    logic                    buf_open, buf_extend;

    logic [4:0]  ident_kind;
    logic [15:0] off16;
    logic        close_v, fresh, fresh_v;
    token_t      close_tok, fresh_tok;

    // Keyword lookup: all seven entries are compared in parallel.
    always_comb begin
        logic hit;
        ident_kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (open_length_reg == 16'(KW_LEN[k]));
            for (int i = 0; i < KW_SPAN; i++) begin
                if (3'(i) < KW_LEN[k] && kw_buf_reg[i] != KW_TEXT[k][KW_SPAN*8-1-8*i -: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                ident_kind = KIND_KW_FIRST + 5'(k);
            end
        end
    end

    assign off16 = 16'(offset_reg);

    always_comb begin
        mode_next        = mode_reg;
        open_start_next  = open_start_reg;
        open_length_next = open_length_reg;
        buf_open         = 1'b0;
        buf_extend       = 1'b0;
        close_v          = 1'b0;
        close_tok        = '0;
        fresh            = 1'b1;
        fresh_v          = 1'b0;
        fresh_tok        = '0;

        unique case (mode_reg)
            MODE_IDENT, MODE_INT: begin
                if ((mode_reg == MODE_IDENT) ? is_letter(in_byte) : is_digit(in_byte)) begin
                    buf_extend = 1'b1;
                    fresh      = 1'b0;
                    if (open_length_reg != LEN_MAX) begin
                        open_length_next = open_length_reg + 16'd1;
                    end
                end else begin
                    close_v          = 1'b1;
                    close_tok.kind   = (mode_reg == MODE_IDENT) ? ident_kind : KIND_INT;
                    close_tok.start  = open_start_reg;
                    close_tok.length = open_length_reg;
                    mode_next        = MODE_IDLE;
                end
            end
            MODE_ASSIGN, MODE_BANG: begin
                close_v         = 1'b1;
                close_tok.start = open_start_reg;
                if (in_byte == CH_EQUAL) begin
                    close_tok.kind   = (mode_reg == MODE_ASSIGN) ? KIND_EQ : KIND_NOT_EQ;
                    close_tok.length = 16'd2;
                    fresh            = 1'b0;
                end else begin
                    close_tok.kind   = (mode_reg == MODE_ASSIGN) ? KIND_ASSIGN : KIND_BANG;
                    close_tok.length = 16'd1;
                end
                mode_next = MODE_IDLE;
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (fresh) begin
            if (in_byte == CH_NUL) begin
                fresh_v          = 1'b1;
                fresh_tok.kind   = KIND_EOF;
                fresh_tok.start  = off16;
                fresh_tok.length = 16'd0;
            end else if (is_space(in_byte)) begin
                fresh_v = 1'b0;
            end else if (in_byte == CH_EQUAL || in_byte == CH_BANG
                         || is_letter(in_byte) || is_digit(in_byte)) begin
                buf_open         = 1'b1;
                open_start_next  = off16;
                open_length_next = 16'd1;
                if (in_byte == CH_EQUAL) begin
                    mode_next = MODE_ASSIGN;
                end else if (in_byte == CH_BANG) begin
                    mode_next = MODE_BANG;
                end else if (is_letter(in_byte)) begin
                    mode_next = MODE_IDENT;
                end else begin
                    mode_next = MODE_INT;
                end
            end else begin
                fresh_v          = 1'b1;
                fresh_tok.kind   = single_kind(in_byte);
                fresh_tok.start  = off16;
                fresh_tok.length = 16'd1;
            end
        end

        offset_next = (in_byte == CH_NUL) ? '0 : offset_reg + 1'b1;
    end

    // Pack the tokens: the closing token always comes first.
    always_comb begin
        scan_out.count = {1'b0, close_v} + {1'b0, fresh_v};
        scan_out.tok0  = close_v ? close_tok : fresh_tok;
        scan_out.tok1  = fresh_tok;
        scan_out.tok0.last = !(close_v && fresh_v);
        scan_out.tok1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            offset_reg      <= '0;
            open_start_reg  <= '0;
            open_length_reg <= '0;
            for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                kw_buf_reg[j] <= '0;
            end
        end else if (in_fire) begin
            mode_reg        <= mode_next;
            offset_reg      <= offset_next;
            open_start_reg  <= open_start_next;
            open_length_reg <= open_length_next;
            for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                if (buf_open) begin
                    kw_buf_reg[j] <= (j == 0) ? in_byte : 8'h00;
                end else if (buf_extend && open_length_reg == 16'(j)) begin
                    kw_buf_reg[j] <= in_byte;
                end
            end
        end
    end

endmodule

>>> hw/rtl/elt_out_fifo.sv
// Four-entry result queue that takes up to two tokens a cycle and hands out one while out_ready is high.
// Depends on elt_pkg.
`timescale 1ns / 1ps

module elt_out_fifo
    import elt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_en,
    input  scan_out_t push_data,
    output logic      out_valid,
    input  logic      out_ready,
    output token_t    out_tok,
    output logic [2:0] level
);

    localparam int DEPTH = 4;

    token_t     mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] level_reg, level_next;
    logic [1:0] push_n;
    logic       pop;

    assign push_n     = push_en ? push_data.count : 2'd0;
    assign out_valid  = (level_reg != 3'd0);
    assign pop        = out_valid && out_ready;
    assign out_tok    = mem_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign level_next = level_reg + {1'b0, push_n} - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_data.tok0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_reg + 2'd1] <= push_data.tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            level_reg  <= level_next;
        end
    end

endmodule
